// ----- rtl/naf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// naf_pkg
// Shared types and constants of the NAL access unit framer.
// ----------------------------------------------------------------------------
package naf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 23;
    localparam int SHIFT_W     = 24;
    localparam int PREFIX_W    = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int RES_MAX     = 4;
    localparam int RES_IDX_W   = $clog2(RES_MAX);
    localparam int RES_CNT_W   = $clog2(RES_MAX + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMING_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_NAL_LENGTH = 1'b1;

    localparam logic MODE_ANNEX_B = 1'b0;
    localparam logic MODE_LENGTH  = 1'b1;

    localparam logic [LEN_W-1:0]  NAL_LIMIT_RESET = 23'd4194304;
    localparam logic [BYTE_W-1:0] NAL_TYPE_MASK   = 8'h1f;
    localparam logic [BYTE_W-1:0] NAL_TYPE_SLICE  = 8'd1;
    localparam logic [BYTE_W-1:0] NAL_TYPE_IDR    = 8'd5;
    localparam logic [BYTE_W-1:0] SC_ZERO         = 8'h00;
    localparam logic [BYTE_W-1:0] SC_ONE          = 8'h01;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              unit_last;
        logic              keyframe;
        logic              length_error;
    } naf_entry_t;

    // one queued command: the results of one input byte
    typedef struct packed {
        logic [RES_IDX_W-1:0]      last_idx;
        naf_entry_t [RES_MAX-1:0]  entry;
    } naf_cmd_t;

    typedef struct packed {
        logic     push;
        naf_cmd_t cmd;
    } naf_push_t;

endpackage
`default_nettype wire

// ----- rtl/naf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// naf_front
// Byte classifier: start code scan, length prefix parse, NAL and unit flags.
// ----------------------------------------------------------------------------
module naf_front import naf_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]       cfg_wr_data,
    input  wire logic                   accept,
    input  wire logic [BYTE_W-1:0]      in_byte,
    output naf_push_t                   push_o
);

    logic                framing_mode_reg;
    logic [LEN_W-1:0]    max_nal_length_reg;

    logic [1:0]          zero_run_reg,        zero_run_next;
    logic [BYTE_W-1:0]   held_byte_reg,       held_byte_next;
    logic                held_valid_reg,      held_valid_next;
    logic                synced_reg,          synced_next;
    logic                nal_has_payload_reg, nal_has_payload_next;
    logic                nal_is_vcl_reg,      nal_is_vcl_next;
    logic                unit_has_idr_reg,    unit_has_idr_next;
    logic [SHIFT_W-1:0]  length_shift_reg,    length_shift_next;
    logic [1:0]          prefix_count_reg,    prefix_count_next;
    logic [LEN_W-1:0]    bytes_remaining_reg, bytes_remaining_next;
    logic                halted_reg,          halted_next;

    logic [RES_CNT_W-1:0] n_items;
    naf_entry_t [RES_MAX-1:0] res;
    logic [1:0]           k_zeros;
    logic [BYTE_W-1:0]    v_byte;
    logic [BYTE_W-1:0]    hdr;
    logic [PREFIX_W-1:0]  len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            framing_mode_reg   <= MODE_ANNEX_B;
            max_nal_length_reg <= NAL_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAMING_MODE:   framing_mode_reg   <= cfg_wr_data[0];
                CFG_MAX_NAL_LENGTH: max_nal_length_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        zero_run_next        = zero_run_reg;
        held_byte_next       = held_byte_reg;
        held_valid_next      = held_valid_reg;
        synced_next          = synced_reg;
        nal_has_payload_next = nal_has_payload_reg;
        nal_is_vcl_next      = nal_is_vcl_reg;
        unit_has_idr_next    = unit_has_idr_reg;
        length_shift_next    = length_shift_reg;
        prefix_count_next    = prefix_count_reg;
        bytes_remaining_next = bytes_remaining_reg;
        halted_next          = halted_reg;
        n_items              = '0;
        res                  = '0;
        k_zeros              = 2'd0;
        v_byte               = SC_ZERO;
        hdr                  = SC_ZERO;
        len                  = {length_shift_reg, in_byte};

        if (!halted_reg) begin
            if (framing_mode_reg == MODE_ANNEX_B) begin
                if (!synced_reg) begin
                    if (in_byte == SC_ZERO) begin
                        if (zero_run_reg != 2'd3) begin
                            zero_run_next = zero_run_reg + 2'd1;
                        end
                    end else if (in_byte == SC_ONE && zero_run_reg[1]) begin
                        // first start code: open with 00 00 00, the 01 follows later
                        synced_next          = 1'b1;
                        zero_run_next        = 2'd0;
                        nal_has_payload_next = 1'b0;
                        held_valid_next      = 1'b0;
                        n_items              = 3'd3;
                    end else begin
                        zero_run_next = 2'd0;
                    end
                end else if (in_byte == SC_ZERO && zero_run_reg != 2'd3) begin
                    zero_run_next = zero_run_reg + 2'd1;
                end else if (in_byte == SC_ONE && zero_run_reg[1]) begin
                    // start code closes the NAL: if it had payload, flush held byte, then 00 00 00
                    if (nal_has_payload_reg) begin
                        if (held_valid_reg) begin
                            res[0].out_byte  = held_byte_reg;
                            res[0].unit_last = nal_is_vcl_reg;
                            res[0].keyframe  = nal_is_vcl_reg & unit_has_idr_reg;
                            n_items          = 3'd4;
                        end else begin
                            n_items = 3'd3;
                        end
                        if (nal_is_vcl_reg) begin
                            unit_has_idr_next = 1'b0;
                        end
                    end
                    held_valid_next      = 1'b0;
                    nal_has_payload_next = 1'b0;
                    nal_is_vcl_next      = 1'b0;
                    zero_run_next        = 2'd0;
                end else begin
                    // payload byte: release pending zeros, hold the new byte
                    if (in_byte != SC_ZERO) begin
                        k_zeros       = zero_run_reg;
                        v_byte        = in_byte;
                        zero_run_next = 2'd0;
                    end
                    if (!nal_has_payload_reg) begin
                        res[0].out_byte      = SC_ONE;
                        n_items              = 3'd1;
                        hdr                  = (k_zeros != 2'd0) ? SC_ZERO : v_byte;
                        nal_is_vcl_next      = ((hdr & NAL_TYPE_MASK) == NAL_TYPE_SLICE) ||
                                               ((hdr & NAL_TYPE_MASK) == NAL_TYPE_IDR);
                        if ((hdr & NAL_TYPE_MASK) == NAL_TYPE_IDR) begin
                            unit_has_idr_next = 1'b1;
                        end
                        nal_has_payload_next = 1'b1;
                    end else if (held_valid_reg) begin
                        res[0].out_byte = held_byte_reg;
                        n_items         = 3'd1;
                    end
                    n_items         = n_items + {1'b0, k_zeros};
                    held_byte_next  = v_byte;
                    held_valid_next = 1'b1;
                end
            end else begin
                if (bytes_remaining_reg == '0) begin
                    if (prefix_count_reg != 2'd3) begin
                        length_shift_next = {length_shift_reg[SHIFT_W-BYTE_W-1:0], in_byte};
                        prefix_count_next = prefix_count_reg + 2'd1;
                    end else begin
                        length_shift_next = '0;
                        prefix_count_next = 2'd0;
                        if (len == '0 || len > {{(PREFIX_W-LEN_W){1'b0}}, max_nal_length_reg})
                        begin
                            halted_next          = 1'b1;
                            res[0].length_error  = 1'b1;
                            n_items              = 3'd1;
                        end else begin
                            bytes_remaining_next = len[LEN_W-1:0];
                            nal_has_payload_next = 1'b0;
                            res[3].out_byte      = SC_ONE;
                            n_items              = 3'd4;
                        end
                    end
                end else begin
                    if (!nal_has_payload_reg) begin
                        nal_is_vcl_next = ((in_byte & NAL_TYPE_MASK) == NAL_TYPE_SLICE) ||
                                          ((in_byte & NAL_TYPE_MASK) == NAL_TYPE_IDR);
                        if ((in_byte & NAL_TYPE_MASK) == NAL_TYPE_IDR) begin
                            unit_has_idr_next = 1'b1;
                        end
                        nal_has_payload_next = 1'b1;
                    end
                    bytes_remaining_next = bytes_remaining_reg - LEN_W'(1);
                    res[0].out_byte      = in_byte;
                    n_items              = 3'd1;
                    if (bytes_remaining_next == '0) begin
                        res[0].unit_last = nal_is_vcl_next;
                        res[0].keyframe  = nal_is_vcl_next & unit_has_idr_next;
                        if (nal_is_vcl_next) begin
                            unit_has_idr_next = 1'b0;
                        end
                        nal_has_payload_next = 1'b0;
                        nal_is_vcl_next      = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg        <= 2'd0;
            held_byte_reg       <= '0;
            held_valid_reg      <= 1'b0;
            synced_reg          <= 1'b0;
            nal_has_payload_reg <= 1'b0;
            nal_is_vcl_reg      <= 1'b0;
            unit_has_idr_reg    <= 1'b0;
            length_shift_reg    <= '0;
            prefix_count_reg    <= 2'd0;
            bytes_remaining_reg <= '0;
            halted_reg          <= 1'b0;
        end else if (accept) begin
            zero_run_reg        <= zero_run_next;
            held_byte_reg       <= held_byte_next;
            held_valid_reg      <= held_valid_next;
            synced_reg          <= synced_next;
            nal_has_payload_reg <= nal_has_payload_next;
            nal_is_vcl_reg      <= nal_is_vcl_next;
            unit_has_idr_reg    <= unit_has_idr_next;
            length_shift_reg    <= length_shift_next;
            prefix_count_reg    <= prefix_count_next;
            bytes_remaining_reg <= bytes_remaining_next;
            halted_reg          <= halted_next;
        end
    end

    always_comb begin
        push_o.push         = accept && (n_items != '0);
        push_o.cmd.entry    = res;
        push_o.cmd.last_idx = n_items[RES_IDX_W-1:0] - RES_IDX_W'(1);
    end

    // a halted block never queues results
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !push_o.push)
        else $error("results queued after halt");

endmodule
`default_nettype wire

// ----- rtl/naf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// naf_queue
// Short command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module naf_queue import naf_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  naf_push_t push_i,
    input  wire logic pop,
    output naf_cmd_t  head,
    output logic      full,
    output logic      empty
);

    naf_cmd_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg,  count_next;
    logic                do_pop;

    assign full   = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i.push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push_i.push && !do_pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (!push_i.push && do_pop) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i.push) begin
            mem[wr_ptr_reg] <= push_i.cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i.push |-> !full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_i.push && !do_pop) |=> (count_reg == $past(count_reg) + Q_CNT_W'(1)))
        else $error("queue count missed a push");

endmodule
`default_nettype wire

// ----- rtl/naf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// naf_back
// Output sequencer: plays out the results of each command one per transaction.
// ----------------------------------------------------------------------------
module naf_back import naf_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  naf_cmd_t               head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_unit_last,
    output logic                   m_keyframe,
    output logic                   m_length_error
);

    naf_cmd_t              cmd_reg;
    logic                  busy_reg, busy_next;
    logic [RES_IDX_W-1:0]  idx_reg,  idx_next;
    logic                  at_end;
    naf_entry_t            cur;

    assign at_end = busy_reg && m_ready && (idx_reg == cmd_reg.last_idx);
    assign pop    = !empty && (!busy_reg || at_end);
    assign cur    = cmd_reg.entry[idx_reg];

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (at_end) begin
            busy_next = 1'b0;
        end else if (busy_reg && m_ready) begin
            idx_next = idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head;
        end
    end

    assign m_valid        = busy_reg;
    assign m_out_byte     = cur.out_byte;
    assign m_unit_last    = cur.unit_last;
    assign m_keyframe     = cur.keyframe;
    assign m_length_error = cur.length_error;

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= cmd_reg.last_idx))
        else $error("result index beyond command");

    a_key_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cur.keyframe |-> cur.unit_last)
        else $error("keyframe without unit end");

endmodule
`default_nettype wire

// ----- rtl/h264_nal_access_unit_framer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h264_nal_access_unit_framer_unit
// Re-frames an H.264 byte stream into start-code delimited access units.
// ----------------------------------------------------------------------------
// Path: with the sequencer idle, the classifier writes a byte's results into
//   the queue when the byte is accepted, and the sequencer loads them into its
//   command register before offering the first result.
// Throughput: one byte per cycle unless the queue is full; a byte's N results
//   take N output transactions (up to four), absorbed by the four-command queue.
// Reset: aresetn synchronous, active low; clears all parse state and the
//   queue, sets framing_mode to 0 and max_nal_length to 4194304.
// ----------------------------------------------------------------------------
module h264_nal_access_unit_framer_unit import naf_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration, write only
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]       cfg_wr_data,
    // stream bytes in
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [BYTE_W-1:0]      s_in_byte,
    // framed bytes out
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [BYTE_W-1:0]           m_out_byte,
    output logic                        m_unit_last,
    output logic                        m_keyframe,
    output logic                        m_length_error
);

    naf_push_t push;
    naf_cmd_t  head;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    logic      s_accept;

    // Take a byte whenever the queue has room; a byte that yields no result
    // simply advances the parser and queues nothing.
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    // Classify each byte and build the results of its transaction.
    naf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .accept      (s_accept),
        .in_byte     (s_in_byte),
        .push_o      (push)
    );

    // Hold the command bursts so front and back stall independently.
    naf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .pop     (q_pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Drain each command one result per output transaction.
    naf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (q_empty),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_unit_last    (m_unit_last),
        .m_keyframe     (m_keyframe),
        .m_length_error (m_length_error)
    );

endmodule
`default_nettype wire
